// ===== hw/rtl/sm83_alu_pkg.sv =====
// ----------------------------------------------------------------------------
// SM83 ALU package
// Operation codes, request and response records and flag constants that are
// shared by the arithmetic and flag unit.
// ----------------------------------------------------------------------------
package sm83_alu_pkg;

    typedef enum logic [5:0] {
        OP_ADD    = 6'd0,
        OP_ADC    = 6'd1,
        OP_SUB    = 6'd2,
        OP_SBC    = 6'd3,
        OP_AND    = 6'd4,
        OP_XOR    = 6'd5,
        OP_OR     = 6'd6,
        OP_CP     = 6'd7,
        OP_INC8   = 6'd8,
        OP_DEC8   = 6'd9,
        OP_RLCA   = 6'd10,
        OP_RRCA   = 6'd11,
        OP_RLA    = 6'd12,
        OP_RRA    = 6'd13,
        OP_DAA    = 6'd14,
        OP_CPL    = 6'd15,
        OP_SCF    = 6'd16,
        OP_CCF    = 6'd17,
        OP_RLC    = 6'd18,
        OP_RRC    = 6'd19,
        OP_RL     = 6'd20,
        OP_RR     = 6'd21,
        OP_SLA    = 6'd22,
        OP_SRA    = 6'd23,
        OP_SWAP   = 6'd24,
        OP_SRL    = 6'd25,
        OP_BIT    = 6'd26,
        OP_RES    = 6'd27,
        OP_SET    = 6'd28,
        OP_ADD16  = 6'd29,
        OP_ADDSP  = 6'd30,
        OP_INC16  = 6'd31,
        OP_DEC16  = 6'd32
    } alu_op_t;

    localparam int FLAG_Z = 3;
    localparam int FLAG_N = 2;
    localparam int FLAG_H = 1;
    localparam int FLAG_C = 0;

    localparam logic [7:0] DAA_LIMIT  = 8'h99;
    localparam logic [7:0] DAA_ADJ_HI = 8'h60;
    localparam logic [7:0] DAA_ADJ_LO = 8'h06;
    localparam logic [3:0] BCD_MAX    = 4'd9;

    typedef struct packed {
        alu_op_t     op;
        logic [15:0] operand_a;
        logic [15:0] operand_b;
        logic [2:0]  bit_index;
        logic [3:0]  flags_in;
    } alu_req_t;

    typedef struct packed {
        logic [15:0] result;
        logic [3:0]  flags_out;
        logic        writes_result;
    } alu_rsp_t;

endpackage

// ===== hw/rtl/sm83_alu_flag_unit_core.sv =====
// ----------------------------------------------------------------------------
// SM83 ALU flag unit core
// Streaming wrapper around the SM83 arithmetic and flag datapath.
// ----------------------------------------------------------------------------
// The unit takes one request per clock cycle while the result side is not
// stalled, and returns one response for each request, in order. A request
// passes through an input register, the combinational datapath and a result
// register, from which its response is presented. Back-pressure on the result
// side stalls the result register, and the input register too once it holds
// a request; an empty result register always lets a new request in.
module sm83_alu_flag_unit_core
    import sm83_alu_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    // [15:0] operand_a, [31:16] operand_b, [34:32] bit_index,
    // [38:35] flags_in, [39] zero.
    input  logic [39:0] s_tdata,
    // [5:0] op.
    input  logic [5:0]  s_tuser,

    output logic        m_tvalid,
    input  logic        m_tready,
    // [15:0] result, [19:16] flags_out, [23:20] zero.
    output logic [23:0] m_tdata,
    // [0] writes_result.
    output logic        m_tuser
);

    alu_req_t req_reg;
    alu_req_t req_next;
    logic     req_valid_reg;
    alu_rsp_t rsp_reg;
    alu_rsp_t rsp_next;
    logic     rsp_valid_reg;
    logic     rsp_advance;
    logic     s_accept;

    assign rsp_advance = m_tready || !rsp_valid_reg;
    assign s_tready    = !req_valid_reg || rsp_advance;
    assign s_accept    = s_tvalid && s_tready;

    always_comb begin
        req_next.op        = alu_op_t'(s_tuser);
        req_next.operand_a = s_tdata[15:0];
        req_next.operand_b = s_tdata[31:16];
        req_next.bit_index = s_tdata[34:32];
        req_next.flags_in  = s_tdata[38:35];
    end

    sm83_alu_datapath u_datapath (
        .req (req_reg),
        .rsp (rsp_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                req_valid_reg <= s_tvalid;
            end
            if (rsp_advance) begin
                rsp_valid_reg <= req_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            req_reg <= req_next;
        end
        if (rsp_advance && req_valid_reg) begin
            rsp_reg <= rsp_next;
        end
    end

    assign m_tvalid = rsp_valid_reg;
    assign m_tdata  = {4'h0, rsp_reg.flags_out, rsp_reg.result};
    assign m_tuser  = rsp_reg.writes_result;

    a_empty_takes_request : assert property (
        @(posedge aclk) disable iff (!aresetn)
        !rsp_valid_reg |-> s_tready
    ) else $error("Request refused while the result register is empty.");

    a_stalled_request_kept : assert property (
        @(posedge aclk) disable iff (!aresetn)
        req_valid_reg && !rsp_advance |=> req_valid_reg
    ) else $error("Pending request dropped during a stall.");

    a_no_write_high_byte : assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> (m_tdata[15:8] == 8'h00)
    ) else $error("Response without write-back carries a non-zero high byte.");

endmodule

// ===== hw/rtl/sm83_alu_datapath.sv =====
// ----------------------------------------------------------------------------
// SM83 ALU datapath
// Combinational arithmetic, logic, shift and flag evaluation for one request.
// ----------------------------------------------------------------------------
module sm83_alu_datapath
    import sm83_alu_pkg::*;
(
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    logic [7:0]  a;
    logic [7:0]  b;
    logic        cin;
    logic        add_cy;
    logic        sub_cy;
    logic [8:0]  sum9;
    logic [4:0]  hsum5;
    logic [8:0]  diff9;
    logic [4:0]  hdiff5;
    logic [7:0]  inc8;
    logic [7:0]  dec8;
    logic [7:0]  bit_mask;
    logic        daa_c;
    logic [7:0]  daa_adj;
    logic [7:0]  daa_val;
    logic [16:0] sum17;
    logic [12:0] hsum13;
    logic [15:0] sp_sum;
    logic [15:0] inc16;
    logic [15:0] dec16;
    logic [7:0]  res8;
    logic [15:0] res_wide;
    logic        is_wide;
    logic        z8;
    logic [3:0]  fl;

    assign a      = req.operand_a[7:0];
    assign b      = req.operand_b[7:0];
    assign fl     = req.flags_in;
    assign cin    = fl[FLAG_C];
    assign add_cy = (req.op == OP_ADC) & cin;
    assign sub_cy = (req.op == OP_SBC) & cin;

    assign sum9   = {1'b0, a} + {1'b0, b} + {8'd0, add_cy};
    assign hsum5  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, add_cy};
    assign diff9  = {1'b0, a} - {1'b0, b} - {8'd0, sub_cy};
    assign hdiff5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, sub_cy};
    assign inc8   = a + 8'd1;
    assign dec8   = a - 8'd1;
    assign bit_mask = 8'd1 << req.bit_index;

    always_comb begin
        daa_c   = cin;
        daa_adj = 8'h00;
        if (!fl[FLAG_N]) begin
            if (cin || (a > DAA_LIMIT)) begin
                daa_adj = daa_adj | DAA_ADJ_HI;
                daa_c   = 1'b1;
            end
            if (fl[FLAG_H] || (a[3:0] > BCD_MAX)) begin
                daa_adj = daa_adj | DAA_ADJ_LO;
            end
            daa_val = a + daa_adj;
        end else begin
            if (cin) begin
                daa_adj = daa_adj | DAA_ADJ_HI;
            end
            if (fl[FLAG_H]) begin
                daa_adj = daa_adj | DAA_ADJ_LO;
            end
            daa_val = a - daa_adj;
        end
    end

    assign sum17  = {1'b0, req.operand_a} + {1'b0, req.operand_b};
    assign hsum13 = {1'b0, req.operand_a[11:0]} + {1'b0, req.operand_b[11:0]};
    assign sp_sum = req.operand_a + {{8{b[7]}}, b};
    assign inc16  = req.operand_a + 16'd1;
    assign dec16  = req.operand_a - 16'd1;

    always_comb begin
        res8     = 8'h00;
        res_wide = 16'h0000;
        is_wide  = 1'b0;
        case (req.op)
            OP_ADD, OP_ADC:                 res8 = sum9[7:0];
            OP_SUB, OP_SBC, OP_CP:          res8 = diff9[7:0];
            OP_AND:                         res8 = a & b;
            OP_XOR:                         res8 = a ^ b;
            OP_OR:                          res8 = a | b;
            OP_INC8:                        res8 = inc8;
            OP_DEC8:                        res8 = dec8;
            OP_RLCA, OP_RLC:                res8 = {a[6:0], a[7]};
            OP_RRCA, OP_RRC:                res8 = {a[0], a[7:1]};
            OP_RLA, OP_RL:                  res8 = {a[6:0], cin};
            OP_RRA, OP_RR:                  res8 = {cin, a[7:1]};
            OP_DAA:                         res8 = daa_val;
            OP_CPL:                         res8 = ~a;
            OP_SLA:                         res8 = {a[6:0], 1'b0};
            OP_SRA:                         res8 = {a[7], a[7:1]};
            OP_SWAP:                        res8 = {a[3:0], a[7:4]};
            OP_SRL:                         res8 = {1'b0, a[7:1]};
            OP_RES:                         res8 = a & ~bit_mask;
            OP_SET:                         res8 = a | bit_mask;
            OP_ADD16: begin
                res_wide = sum17[15:0];
                is_wide  = 1'b1;
            end
            OP_ADDSP: begin
                res_wide = sp_sum;
                is_wide  = 1'b1;
            end
            OP_INC16: begin
                res_wide = inc16;
                is_wide  = 1'b1;
            end
            OP_DEC16: begin
                res_wide = dec16;
                is_wide  = 1'b1;
            end
            default:                        res8 = 8'h00;
        endcase
    end

    assign z8 = (res8 == 8'h00);

    always_comb begin
        rsp.result        = is_wide ? res_wide : {8'h00, res8};
        rsp.flags_out     = fl;
        rsp.writes_result = 1'b1;
        case (req.op)
            OP_ADD, OP_ADC:
                rsp.flags_out = {z8, 1'b0, hsum5[4], sum9[8]};
            OP_SUB, OP_SBC:
                rsp.flags_out = {z8, 1'b1, hdiff5[4], diff9[8]};
            OP_CP: begin
                rsp.flags_out     = {z8, 1'b1, hdiff5[4], diff9[8]};
                rsp.writes_result = 1'b0;
            end
            OP_AND:
                rsp.flags_out = {z8, 1'b0, 1'b1, 1'b0};
            OP_XOR, OP_OR, OP_SWAP:
                rsp.flags_out = {z8, 3'b000};
            OP_INC8:
                rsp.flags_out = {z8, 1'b0, (inc8[3:0] == 4'h0), cin};
            OP_DEC8:
                rsp.flags_out = {z8, 1'b1, (dec8[3:0] == 4'hF), cin};
            OP_RLCA, OP_RLA:
                rsp.flags_out = {3'b000, a[7]};
            OP_RRCA, OP_RRA:
                rsp.flags_out = {3'b000, a[0]};
            OP_DAA:
                rsp.flags_out = {z8, fl[FLAG_N], 1'b0, daa_c};
            OP_CPL:
                rsp.flags_out = {fl[FLAG_Z], 1'b1, 1'b1, cin};
            OP_SCF: begin
                rsp.flags_out     = {fl[FLAG_Z], 3'b001};
                rsp.writes_result = 1'b0;
            end
            OP_CCF: begin
                rsp.flags_out     = {fl[FLAG_Z], 2'b00, ~cin};
                rsp.writes_result = 1'b0;
            end
            OP_RLC, OP_RL, OP_SLA:
                rsp.flags_out = {z8, 2'b00, a[7]};
            OP_RRC, OP_RR, OP_SRA, OP_SRL:
                rsp.flags_out = {z8, 2'b00, a[0]};
            OP_BIT: begin
                rsp.flags_out     = {~a[req.bit_index], 1'b0, 1'b1, cin};
                rsp.writes_result = 1'b0;
            end
            OP_RES, OP_SET, OP_INC16, OP_DEC16:
                rsp.flags_out = fl;
            OP_ADD16:
                rsp.flags_out = {fl[FLAG_Z], 1'b0, hsum13[12], sum17[16]};
            OP_ADDSP:
                rsp.flags_out = {2'b00, hsum5[4], sum9[8]};
            default: begin
                rsp.flags_out     = fl;
                rsp.writes_result = 1'b0;
            end
        endcase
    end

endmodule

// ===== bench/sm83_alu_flag_unit_checker.sv =====
// ----------------------------------------------------------------------------
// SM83 ALU flag unit checker
// Watches the request and response streams of the flag unit. It works out
// the expected value, flags and write-back bit for every accepted request,
// and compares each response in order against the oldest expectation.
// ----------------------------------------------------------------------------
module sm83_alu_flag_unit_checker
    import sm83_alu_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic [5:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic        m_tuser,
    output int          fail_count,
    output int          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    alu_rsp_t pending_outcomes[$];
    alu_rsp_t oldest;
    int       mismatches = 0;
    int       pending_count = 0;
    int       rsp_index = 0;

    assign fail_count  = mismatches;
    assign outstanding = pending_count;

    function automatic logic [3:0] flag_word(logic z, logic n, logic h, logic c);
        logic [3:0] f;
        f = 4'h0;
        f[FLAG_Z] = z;
        f[FLAG_N] = n;
        f[FLAG_H] = h;
        f[FLAG_C] = c;
        return f;
    endfunction

    function automatic alu_rsp_t alu_outcome(logic [5:0] code, logic [15:0] a16,
                                             logic [15:0] b16, logic [2:0] bi,
                                             logic [3:0] fl);
        alu_rsp_t    o;
        logic [7:0]  a;
        logic [7:0]  b;
        logic [7:0]  r8;
        logic        cin;
        logic        cc;
        logic        nf;
        logic        hf;
        logic        cf;
        logic        wide;
        logic [8:0]  s9;
        logic [4:0]  s5;
        logic [12:0] s13;
        logic [16:0] s17;
        a = a16[7:0];
        b = b16[7:0];
        cin = fl[FLAG_C];
        r8 = 8'h00;
        wide = 1'b0;
        o.result = 16'h0000;
        o.flags_out = fl;
        o.writes_result = 1'b1;
        case (code)
            OP_ADD, OP_ADC: begin
                cc = (code == OP_ADC) ? cin : 1'b0;
                s9 = {1'b0, a} + {1'b0, b} + 9'(cc);
                s5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + 5'(cc);
                r8 = s9[7:0];
                o.flags_out = flag_word(r8 == 8'h00, 1'b0, s5[4], s9[8]);
            end
            OP_SUB, OP_SBC, OP_CP: begin
                cc = (code == OP_SBC) ? cin : 1'b0;
                r8 = a - b - 8'(cc);
                hf = {1'b0, a[3:0]} < ({1'b0, b[3:0]} + 5'(cc));
                cf = {1'b0, a} < ({1'b0, b} + 9'(cc));
                o.flags_out = flag_word(r8 == 8'h00, 1'b1, hf, cf);
                if (code == OP_CP) begin
                    o.writes_result = 1'b0;
                end
            end
            OP_AND: begin
                r8 = a & b;
                o.flags_out = flag_word(r8 == 8'h00, 1'b0, 1'b1, 1'b0);
            end
            OP_XOR: begin
                r8 = a ^ b;
                o.flags_out = flag_word(r8 == 8'h00, 1'b0, 1'b0, 1'b0);
            end
            OP_OR: begin
                r8 = a | b;
                o.flags_out = flag_word(r8 == 8'h00, 1'b0, 1'b0, 1'b0);
            end
            OP_INC8: begin
                r8 = a + 8'h01;
                o.flags_out = flag_word(r8 == 8'h00, 1'b0, r8[3:0] == 4'h0, cin);
            end
            OP_DEC8: begin
                r8 = a - 8'h01;
                o.flags_out = flag_word(r8 == 8'h00, 1'b1, r8[3:0] == 4'hF, cin);
            end
            OP_RLCA: begin
                r8 = {a[6:0], a[7]};
                o.flags_out = flag_word(1'b0, 1'b0, 1'b0, a[7]);
            end
            OP_RRCA: begin
                r8 = {a[0], a[7:1]};
                o.flags_out = flag_word(1'b0, 1'b0, 1'b0, a[0]);
            end
            OP_RLA: begin
                r8 = {a[6:0], cin};
                o.flags_out = flag_word(1'b0, 1'b0, 1'b0, a[7]);
            end
            OP_RRA: begin
                r8 = {cin, a[7:1]};
                o.flags_out = flag_word(1'b0, 1'b0, 1'b0, a[0]);
            end
            OP_DAA: begin
                nf = fl[FLAG_N];
                hf = fl[FLAG_H];
                cf = cin;
                r8 = a;
                if (!nf) begin
                    if (cf || a > DAA_LIMIT) begin
                        r8 = r8 + DAA_ADJ_HI;
                        cf = 1'b1;
                    end
                    if (hf || a[3:0] > BCD_MAX) begin
                        r8 = r8 + DAA_ADJ_LO;
                    end
                end else begin
                    if (cf) begin
                        r8 = r8 - DAA_ADJ_HI;
                    end
                    if (hf) begin
                        r8 = r8 - DAA_ADJ_LO;
                    end
                end
                o.flags_out = flag_word(r8 == 8'h00, nf, 1'b0, cf);
            end
            OP_CPL: begin
                r8 = ~a;
                o.flags_out = fl | flag_word(1'b0, 1'b1, 1'b1, 1'b0);
            end
            OP_SCF: begin
                o.writes_result = 1'b0;
                o.flags_out = flag_word(fl[FLAG_Z], 1'b0, 1'b0, 1'b1);
            end
            OP_CCF: begin
                o.writes_result = 1'b0;
                o.flags_out = flag_word(fl[FLAG_Z], 1'b0, 1'b0, !cin);
            end
            OP_RLC: begin
                r8 = {a[6:0], a[7]};
                o.flags_out = flag_word(r8 == 8'h00, 1'b0, 1'b0, a[7]);
            end
            OP_RRC: begin
                r8 = {a[0], a[7:1]};
                o.flags_out = flag_word(r8 == 8'h00, 1'b0, 1'b0, a[0]);
            end
            OP_RL: begin
                r8 = {a[6:0], cin};
                o.flags_out = flag_word(r8 == 8'h00, 1'b0, 1'b0, a[7]);
            end
            OP_RR: begin
                r8 = {cin, a[7:1]};
                o.flags_out = flag_word(r8 == 8'h00, 1'b0, 1'b0, a[0]);
            end
            OP_SLA: begin
                r8 = {a[6:0], 1'b0};
                o.flags_out = flag_word(r8 == 8'h00, 1'b0, 1'b0, a[7]);
            end
            OP_SRA: begin
                r8 = {a[7], a[7:1]};
                o.flags_out = flag_word(r8 == 8'h00, 1'b0, 1'b0, a[0]);
            end
            OP_SWAP: begin
                r8 = {a[3:0], a[7:4]};
                o.flags_out = flag_word(r8 == 8'h00, 1'b0, 1'b0, 1'b0);
            end
            OP_SRL: begin
                r8 = {1'b0, a[7:1]};
                o.flags_out = flag_word(r8 == 8'h00, 1'b0, 1'b0, a[0]);
            end
            OP_BIT: begin
                o.writes_result = 1'b0;
                o.flags_out = flag_word(!a[bi], 1'b0, 1'b1, cin);
            end
            OP_RES: r8 = a & ~(8'h01 << bi);
            OP_SET: r8 = a | (8'h01 << bi);
            OP_ADD16: begin
                wide = 1'b1;
                s17 = {1'b0, a16} + {1'b0, b16};
                s13 = {1'b0, a16[11:0]} + {1'b0, b16[11:0]};
                o.result = s17[15:0];
                o.flags_out = flag_word(fl[FLAG_Z], 1'b0, s13[12], s17[16]);
            end
            OP_ADDSP: begin
                wide = 1'b1;
                s9 = {1'b0, a} + {1'b0, b};
                s5 = {1'b0, a[3:0]} + {1'b0, b[3:0]};
                o.result = a16 + {{8{b[7]}}, b};
                o.flags_out = flag_word(1'b0, 1'b0, s5[4], s9[8]);
            end
            OP_INC16: begin
                wide = 1'b1;
                o.result = a16 + 16'h0001;
            end
            OP_DEC16: begin
                wide = 1'b1;
                o.result = a16 - 16'h0001;
            end
            default: begin
                o.writes_result = 1'b0;
            end
        endcase
        if (!wide) begin
            o.result = {8'h00, r8};
        end
        return o;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        mismatches++;
        $display("MISMATCH at response %0d, %s: got %h, expected %h",
                 rsp_index, what, got, want);
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (pending_outcomes.size() == 0) begin
                    report_mismatch("response with no request waiting", m_tdata[15:0], 16'h0000);
                end else begin
                    oldest = pending_outcomes.pop_front();
                    if (m_tdata[15:0] !== oldest.result) begin
                        report_mismatch("result", m_tdata[15:0], oldest.result);
                    end
                    if (m_tdata[19:16] !== oldest.flags_out) begin
                        report_mismatch("flags", 16'(m_tdata[19:16]), 16'(oldest.flags_out));
                    end
                    if (m_tuser !== oldest.writes_result) begin
                        report_mismatch("write-back", 16'(m_tuser), 16'(oldest.writes_result));
                    end
                end
                rsp_index++;
            end
            if (s_tvalid && s_tready) begin
                pending_outcomes.push_back(alu_outcome(s_tuser, s_tdata[15:0], s_tdata[31:16],
                                                       s_tdata[34:32], s_tdata[38:35]));
            end
            pending_count = pending_outcomes.size();
        end
    end

endmodule

// ===== bench/sm83_alu_flag_unit_core_tb.sv =====
// ----------------------------------------------------------------------------
// SM83 ALU flag unit core testbench
// Drives directed and random requests through the flag unit with random
// gaps on both streams, bar one gap-free run, and reports the verdict of the attached checker.
// ----------------------------------------------------------------------------
module sm83_alu_flag_unit_core_tb
    import sm83_alu_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [5:0] OP_CODE_TOP = 6'h3F;
    localparam logic [3:0] F_Z = 4'(1 << FLAG_Z);
    localparam logic [3:0] F_N = 4'(1 << FLAG_N);
    localparam logic [3:0] F_H = 4'(1 << FLAG_H);
    localparam logic [3:0] F_C = 4'(1 << FLAG_C);

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic [5:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tuser;
    int          fail_count;
    int          outstanding;
    logic        no_gaps = 1'b0;

    always #10 aclk = ~aclk;

    sm83_alu_flag_unit_core DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    sm83_alu_flag_unit_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always @(posedge aclk) begin
        m_tready <= no_gaps || ($urandom_range(0, 99) >= 21);
    end

    task automatic send_request(input logic [5:0] code, input logic [15:0] a,
                                input logic [15:0] b, input logic [2:0] bi,
                                input logic [3:0] fl);
        while (!no_gaps && $urandom_range(0, 99) < 21) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, fl, bi, b, a};
        s_tuser  <= code;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
    endtask

    function automatic logic [15:0] pick_operand();
        logic [7:0] edges[8];
        edges = '{8'h00, 8'h0F, 8'h10, 8'h7F, 8'h80, 8'h99, 8'h9A, 8'hFF};
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return {8'($urandom), edges[$urandom_range(0, 7)]};
            3: return 16'h0FFF + 16'($urandom_range(0, 2)) + (16'($urandom_range(0, 1)) << 12);
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        logic [15:0] levels[4];
        logic [5:0]  code;
        levels = '{16'h0000, 16'hFFFF, 16'h00FF, 16'hFF00};
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int k = OP_ADD; k <= OP_DEC16 + 2; k++) begin
            code = (k == OP_DEC16 + 2) ? OP_CODE_TOP : 6'(k);
            send_request(code, levels[k % 4], levels[(k + 1) % 4], 3'(k * 7),
                         (k % 2) ? 4'hF : 4'h0);
        end
        send_request(OP_DAA, 16'h009A, 16'h0000, 3'd0, 4'h0);
        send_request(OP_DAA, 16'h0033, 16'h0000, 3'd0, F_H);
        send_request(OP_DAA, 16'h0000, 16'h0000, 3'd0, F_N | F_H | F_C);
        send_request(OP_ADDSP, 16'h0001, 16'h00FF, 3'd0, F_Z | F_N);
        send_request(OP_ADDSP, 16'hFF80, 16'h0080, 3'd0, 4'h0);
        send_request(OP_ADD16, 16'h0FFF, 16'h0001, 3'd0, F_Z);
        send_request(OP_CP, 16'h0042, 16'h0042, 3'd0, 4'h0);
        send_request(OP_SBC, 16'h0010, 16'h000F, 3'd0, F_C);
        send_request(OP_ADC, 16'h00FF, 16'h0000, 3'd0, F_C);
        send_request(OP_BIT, 16'h0080, 16'h0000, 3'd7, 4'h0);

        for (int i = 0; i < 450; i++) begin
            no_gaps = (i >= 150 && i < 270);
            if ($urandom_range(0, 19) == 0) begin
                code = 6'($urandom_range(OP_DEC16 + 1, OP_CODE_TOP));
            end else begin
                code = 6'($urandom_range(OP_ADD, OP_DEC16));
            end
            send_request(code, pick_operand(), pick_operand(), 3'($urandom_range(0, 7)),
                         4'($urandom_range(0, 15)));
        end
        no_gaps = 1'b0;
        s_tvalid <= 1'b0;

        @(posedge aclk);
        while (outstanding != 0) begin
            @(posedge aclk);
        end
        repeat (10) @(posedge aclk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
